// ----- rtl/lfpd_pkg.sv -----
package lfpd_pkg;

   localparam int NUM_SENSORS = 5;
   localparam int SAMPLE_W    = 12;
   localparam int GAIN_W      = 10;
   localparam int CSR_IDX_W   = 3;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_4   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV = 3'd6;

   localparam logic [SAMPLE_W-1:0] THRESH_RST_0 = 12'd1961;
   localparam logic [SAMPLE_W-1:0] THRESH_RST_1 = 12'd1958;
   localparam logic [SAMPLE_W-1:0] THRESH_RST_2 = 12'd1959;
   localparam logic [SAMPLE_W-1:0] THRESH_RST_3 = 12'd1957;
   localparam logic [SAMPLE_W-1:0] THRESH_RST_4 = 12'd1959;

   // sensor patterns with a known line position
   localparam logic [4:0] PAT_ERR_NEG4 = 5'd1;
   localparam logic [4:0] PAT_ERR_NEG3 = 5'd3;
   localparam logic [4:0] PAT_ERR_NEG2 = 5'd2;
   localparam logic [4:0] PAT_ERR_NEG1 = 5'd6;
   localparam logic [4:0] PAT_CENTER   = 5'd4;
   localparam logic [4:0] PAT_ERR_POS1 = 5'd12;
   localparam logic [4:0] PAT_ERR_POS2 = 5'd8;
   localparam logic [4:0] PAT_ERR_POS3 = 5'd24;
   localparam logic [4:0] PAT_ERR_POS4 = 5'd16;
   localparam logic [4:0] PAT_ALL      = 5'd31;

   localparam logic [3:0] STOP_MAX  = 4'd15;
   localparam logic [3:0] STOP_HALT = 4'd2;

   localparam logic signed [15:0] PD_MAX = 16'sd100;
   localparam logic signed [15:0] PD_MIN = -16'sd100;
   localparam logic signed [8:0]  SPEED_BASE = 9'sd100;
   localparam logic [7:0]         SPEED_IDLE = 8'd50;
   localparam logic [7:0]         SPEED_STOP = 8'd0;

   typedef struct packed {
      logic [7:0]        left_speed;
      logic [7:0]        right_speed;
      logic signed [3:0] line_error;
      logic              halted;
   } rsp_type;

endpackage

// ----- rtl/lfpd_lane.sv -----
module lfpd_lane
   import lfpd_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] threshold,
   output logic                dark
);

   logic dark_ff;
   logic dark_in;

   assign dark_in = (sample < threshold);

   always_ff @(posedge clock) begin
      if (load) begin
         dark_ff <= dark_in;
      end
   end

   assign dark = dark_ff;

endmodule

// ----- rtl/lfpd_merge.sv -----
module lfpd_merge
   import lfpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [NUM_SENSORS-1:0]   pattern,
   input  logic signed [GAIN_W-1:0] gain_prop,
   input  logic signed [GAIN_W-1:0] gain_deriv,
   output rsp_type                  rsp
);

   logic signed [3:0] last_error_ff;
   logic [4:0]        last_pattern_ff;
   logic [3:0]        stop_ff;
   rsp_type           rsp_ff;

   logic signed [3:0]  err_in;
   logic [3:0]         stop_in;
   logic signed [4:0]  err_diff;
   logic signed [13:0] p_term;
   logic signed [14:0] d_term;
   logic signed [15:0] pd_sum;
   logic signed [7:0]  pd;
   logic signed [8:0]  left_s;
   logic signed [8:0]  right_s;
   rsp_type            rsp_in;

   // decode line position and update the stop counter
   always_comb begin
      err_in  = last_error_ff;
      stop_in = stop_ff;
      case (pattern)
         PAT_ERR_NEG4: err_in = -4'sd4;
         PAT_ERR_NEG3: err_in = -4'sd3;
         PAT_ERR_NEG2: err_in = -4'sd2;
         PAT_ERR_NEG1: err_in = -4'sd1;
         PAT_CENTER:   err_in = 4'sd0;
         PAT_ERR_POS1: err_in = 4'sd1;
         PAT_ERR_POS2: err_in = 4'sd2;
         PAT_ERR_POS3: err_in = 4'sd3;
         PAT_ERR_POS4: begin
            err_in  = 4'sd4;
            stop_in = 4'd0;
         end
         PAT_ALL: begin
            // count entries into the stop marker only
            if (last_pattern_ff != PAT_ALL && stop_ff != STOP_MAX) begin
               stop_in = stop_ff + 4'd1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      err_diff = 5'(err_in) - 5'(last_error_ff);
      p_term   = 14'(gain_prop) * 14'(err_in);
      d_term   = 15'(gain_deriv) * 15'(err_diff);
      pd_sum   = 16'(p_term) + 16'(d_term);
      if (pd_sum > PD_MAX) begin
         pd = 8'sd100;
      end else if (pd_sum < PD_MIN) begin
         pd = -8'sd100;
      end else begin
         pd = pd_sum[7:0];
      end
      left_s  = SPEED_BASE - {pd[7], pd};
      right_s = SPEED_BASE + {pd[7], pd};

      rsp_in.line_error = err_in;
      rsp_in.halted     = (stop_in == STOP_HALT);
      if (rsp_in.halted) begin
         rsp_in.left_speed  = SPEED_STOP;
         rsp_in.right_speed = SPEED_STOP;
      end else if (err_in > 4'sd0) begin
         rsp_in.left_speed  = left_s[7:0];
         rsp_in.right_speed = SPEED_BASE[7:0];
      end else if (err_in < 4'sd0) begin
         rsp_in.left_speed  = SPEED_BASE[7:0];
         rsp_in.right_speed = right_s[7:0];
      end else begin
         rsp_in.left_speed  = SPEED_IDLE;
         rsp_in.right_speed = SPEED_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff   <= 4'sd0;
         last_pattern_ff <= 5'd0;
         stop_ff         <= 4'd0;
      end else if (load) begin
         last_error_ff   <= err_in;
         last_pattern_ff <= pattern;
         stop_ff         <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ----- rtl/line_follow_pd_steering.sv -----
// Line follower PD steering block.
// Request channel (req_*): one frame of five 12-bit reflectance samples per
// item. Each sample below its threshold register marks its sensor dark; the
// five dark bits form a pattern that sets the line error, the stop counter and
// the PD steering term.
// Response channel (rsp_*): one item per request with left and right motor
// duty (0..200), the line error (-4..+4) and the halted flag.
// Configuration (csr_*): thresholds at indexes 0..4, proportional gain at 5,
// derivative gain at 6; a write lands at the clock edge where csr_we is high.
// Write only while no item is in flight.
// Pipeline: the five compare lanes register the dark bits, then the merge
// stage decodes the pattern, updates state and registers the result.
// Throughput: one item per cycle while the receiver does not stall; the merge
// stage holds the per-frame state and closes its loop on each item it loads.
// When the receiver stalls, the response register holds; an empty lane stage
// still takes one more item, then req_ready drops until the response is taken.
// Reset clears the pipeline, the line state and the stop counter, and loads
// the default thresholds and zero gains.
module line_follow_pd_steering
   import lfpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample_0,
   input  logic [SAMPLE_W-1:0]   req_sample_1,
   input  logic [SAMPLE_W-1:0]   req_sample_2,
   input  logic [SAMPLE_W-1:0]   req_sample_3,
   input  logic [SAMPLE_W-1:0]   req_sample_4,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_left_speed,
   output logic [7:0]            rsp_right_speed,
   output logic signed [3:0]     rsp_line_error,
   output logic                  rsp_halted,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SAMPLE_W-1:0]   csr_wdata
);

   logic [SAMPLE_W-1:0]     thresh_ff [NUM_SENSORS];
   logic signed [GAIN_W-1:0] gain_prop_ff;
   logic signed [GAIN_W-1:0] gain_deriv_ff;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic accept;
   logic merge_load;

   logic [SAMPLE_W-1:0]    sample_arr [NUM_SENSORS];
   logic [NUM_SENSORS-1:0] pattern;
   rsp_type                rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff[0]  <= THRESH_RST_0;
         thresh_ff[1]  <= THRESH_RST_1;
         thresh_ff[2]  <= THRESH_RST_2;
         thresh_ff[3]  <= THRESH_RST_3;
         thresh_ff[4]  <= THRESH_RST_4;
         gain_prop_ff  <= '0;
         gain_deriv_ff <= '0;
      end else if (csr_we) begin
         if (csr_index inside {[CSR_THRESH_0:CSR_THRESH_4]}) begin
            thresh_ff[csr_index] <= csr_wdata;
         end else if (csr_index == CSR_GAIN_PROP) begin
            gain_prop_ff <= csr_wdata[GAIN_W-1:0];
         end else if (csr_index == CSR_GAIN_DERIV) begin
            gain_deriv_ff <= csr_wdata[GAIN_W-1:0];
         end
      end
   end

   // pipeline control: a stage moves when the one after it is free
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || advance;
   assign accept     = req_valid && req_ready;
   assign merge_load = s1_valid_ff && advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (merge_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sample_arr[0] = req_sample_0;
   assign sample_arr[1] = req_sample_1;
   assign sample_arr[2] = req_sample_2;
   assign sample_arr[3] = req_sample_3;
   assign sample_arr[4] = req_sample_4;

   for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
      lfpd_lane u_lane (
         .clock     (clock),
         .load      (accept),
         .sample    (sample_arr[g]),
         .threshold (thresh_ff[g]),
         .dark      (pattern[g])
      );
   end

   lfpd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .pattern    (pattern),
      .gain_prop  (gain_prop_ff),
      .gain_deriv (gain_deriv_ff),
      .rsp        (rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = rsp.left_speed;
   assign rsp_right_speed = rsp.right_speed;
   assign rsp_line_error  = rsp.line_error;
   assign rsp_halted      = rsp.halted;

endmodule

// ----- rtl/lfpd_checker.sv -----
module lfpd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [7:0]        rsp_left_speed,
   input logic [7:0]        rsp_right_speed,
   input logic signed [3:0] rsp_line_error,
   input logic              rsp_halted
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed)
         && $stable(rsp_right_speed) && $stable(rsp_line_error)
         && $stable(rsp_halted))
      else $error("response changed while stalled");

   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> rsp_left_speed == 8'd0 && rsp_right_speed == 8'd0)
      else $error("halted item with nonzero speed");

   a_center_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_halted && rsp_line_error == 4'sd0
         |-> rsp_left_speed == 8'd50 && rsp_right_speed == 8'd50)
      else $error("centered item without idle speed");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_speed <= 8'd200 && rsp_right_speed <= 8'd200
         && rsp_line_error >= -4'sd4 && rsp_line_error <= 4'sd4)
      else $error("speed or error out of range");

   a_one_side_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_halted && rsp_line_error != 4'sd0
         |-> rsp_left_speed == 8'd100 || rsp_right_speed == 8'd100)
      else $error("steering item without a full-speed side");

endmodule

bind line_follow_pd_steering lfpd_checker u_lfpd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_left_speed  (rsp_left_speed),
   .rsp_right_speed (rsp_right_speed),
   .rsp_line_error  (rsp_line_error),
   .rsp_halted      (rsp_halted)
);

// ----- bench/tb_line_follow_pd_steering.sv -----
module tb_line_follow_pd_steering;
   timeunit 1ns;
   timeprecision 1ps;
   import lfpd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int PHASES           = 8;
   localparam int FRAMES_PER_PHASE = 142;
   localparam int QUIET_LIMIT      = 1000;
   localparam int PIPE_DEPTH       = 2;
   localparam logic [SAMPLE_W-1:0] DK = '0;
   localparam logic [SAMPLE_W-1:0] LT = '1;

   // index i holds sample_i
   typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] frame_type;
   typedef struct packed {
      frame_type smp;
      logic      typed;
      rsp_type   want;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample_0 = '0;
   logic [SAMPLE_W-1:0]  req_sample_1 = '0;
   logic [SAMPLE_W-1:0]  req_sample_2 = '0;
   logic [SAMPLE_W-1:0]  req_sample_3 = '0;
   logic [SAMPLE_W-1:0]  req_sample_4 = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_left_speed;
   logic [7:0]           rsp_right_speed;
   logic signed [3:0]    rsp_line_error;
   logic                 rsp_halted;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]  csr_wdata = '0;

   // side band for the item on the request port: typed-in response, if any
   logic    req_typed = 1'b0;
   rsp_type req_want = '0;

   // steering predictor state
   logic [SAMPLE_W-1:0] thr_model [NUM_SENSORS];
   int                  kp_model;
   int                  kd_model;
   int                  last_err_model;
   logic [4:0]          last_pat_model;
   logic [3:0]          stops_model;

   rsp_type steer_queue [$];
   int      mismatches = 0;
   int      quiet_cycles = 0;
   int      stall_left = 0;
   int      idle_pct = 20;
   int      stall_pct = 20;
   bit      calm = 1'b0;

   logic [SAMPLE_W-1:0] plan_thr [NUM_SENSORS];
   logic [GAIN_W-1:0]   plan_kp;
   logic [GAIN_W-1:0]   plan_kd;

   line_follow_pd_steering dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_0    (req_sample_0),
      .req_sample_1    (req_sample_1),
      .req_sample_2    (req_sample_2),
      .req_sample_3    (req_sample_3),
      .req_sample_4    (req_sample_4),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_line_error  (rsp_line_error),
      .rsp_halted      (rsp_halted),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 40)
         $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic rsp_type steer_predict(input frame_type f);
      logic [4:0] pat;
      int         err;
      int         pd;
      int         left;
      int         right;
      rsp_type    r;
      pat = '0;
      for (int i = 0; i < NUM_SENSORS; i++)
         pat[i] = f[i] < thr_model[i];
      err = last_err_model;
      case (pat)
         PAT_ERR_NEG4: err = -4;
         PAT_ERR_NEG3: err = -3;
         PAT_ERR_NEG2: err = -2;
         PAT_ERR_NEG1: err = -1;
         PAT_CENTER:   err = 0;
         PAT_ERR_POS1: err = 1;
         PAT_ERR_POS2: err = 2;
         PAT_ERR_POS3: err = 3;
         PAT_ERR_POS4: begin
            err = 4;
            stops_model = '0;
         end
         // count entries into the all-dark pattern, saturating
         PAT_ALL: if (last_pat_model != PAT_ALL && stops_model < STOP_MAX)
            stops_model = stops_model + 4'd1;
         default: ;
      endcase
      last_pat_model = pat;

      pd = kp_model * err + kd_model * (err - last_err_model);
      if (pd > PD_MAX)
         pd = PD_MAX;
      else if (pd < PD_MIN)
         pd = PD_MIN;

      if (err > 0) begin
         left = SPEED_BASE - pd;
         right = SPEED_BASE;
      end else if (err < 0) begin
         left = SPEED_BASE;
         right = SPEED_BASE + pd;
      end else begin
         left = SPEED_IDLE;
         right = SPEED_IDLE;
      end
      r.halted = stops_model == STOP_HALT;
      if (r.halted) begin
         left = SPEED_STOP;
         right = SPEED_STOP;
      end
      last_err_model = err;

      r.left_speed = left[7:0];
      r.right_speed = right[7:0];
      r.line_error = err[3:0];
      return r;
   endfunction

   // Response check, request capture, register tracking and receiver stalls
   // all sit in one block so their order within an edge is fixed.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         thr_model[0] = THRESH_RST_0;
         thr_model[1] = THRESH_RST_1;
         thr_model[2] = THRESH_RST_2;
         thr_model[3] = THRESH_RST_3;
         thr_model[4] = THRESH_RST_4;
         kp_model = 0;
         kd_model = 0;
         last_err_model = 0;
         last_pat_model = '0;
         stops_model = '0;
         steer_queue.delete();
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (steer_queue.size() == 0) begin
               report_mismatch($sformatf("response with no frame pending: %0d %0d %0d %0d",
                  rsp_left_speed, rsp_right_speed, rsp_line_error, rsp_halted));
            end else begin
               want = steer_queue.pop_front();
               if (rsp_left_speed !== want.left_speed)
                  report_mismatch($sformatf("left_speed %0d, want %0d",
                     rsp_left_speed, want.left_speed));
               if (rsp_right_speed !== want.right_speed)
                  report_mismatch($sformatf("right_speed %0d, want %0d",
                     rsp_right_speed, want.right_speed));
               if (rsp_line_error !== want.line_error)
                  report_mismatch($sformatf("line_error %0d, want %0d",
                     rsp_line_error, want.line_error));
               if (rsp_halted !== want.halted)
                  report_mismatch($sformatf("halted %0d, want %0d",
                     rsp_halted, want.halted));
            end
         end

         if (req_valid && req_ready) begin
            want = steer_predict({req_sample_4, req_sample_3, req_sample_2,
                                  req_sample_1, req_sample_0});
            steer_queue.push_back(req_typed ? req_want : want);
         end

         if (csr_we) begin
            if (csr_index <= CSR_THRESH_4)
               thr_model[csr_index - CSR_THRESH_0] = csr_wdata;
            else if (csr_index == CSR_GAIN_PROP)
               kp_model = int'($signed(csr_wdata[GAIN_W-1:0]));
            else if (csr_index == CSR_GAIN_DERIV)
               kd_model = int'($signed(csr_wdata[GAIN_W-1:0]));
         end

         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end

      if (reset || calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_frame(input frame_type f, input logic typed, input rsp_type want);
      req_valid <= 1'b1;
      req_sample_0 <= f[0];
      req_sample_1 <= f[1];
      req_sample_2 <= f[2];
      req_sample_3 <= f[3];
      req_sample_4 <= f[4];
      req_typed <= typed;
      req_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic maybe_idle();
      if (!calm && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   endtask

   // drop valid and hold until every response is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (steer_queue.size() != 0);
      repeat (PIPE_DEPTH) @(posedge clock);
   endtask

   task automatic load_plan();
      for (int i = 0; i < NUM_SENSORS; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_THRESH_0 + CSR_IDX_W'(i);
         csr_wdata <= plan_thr[i];
         @(posedge clock);
      end
      // upper data bits above the gain width must be dropped
      csr_index <= CSR_GAIN_PROP;
      csr_wdata <= {2'($urandom), plan_kp};
      @(posedge clock);
      csr_index <= CSR_GAIN_DERIV;
      csr_wdata <= {2'($urandom), plan_kd};
      @(posedge clock);
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= SAMPLE_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic frame_type frame_for(input logic [4:0] pat);
      frame_type f;
      bit        at_bound;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         at_bound = $urandom_range(3) == 0;
         if (pat[i] && plan_thr[i] != DK)
            f[i] = at_bound ? plan_thr[i] - 12'd1 : SAMPLE_W'($urandom_range(plan_thr[i] - 1));
         else
            f[i] = at_bound ? plan_thr[i] : SAMPLE_W'($urandom_range(LT, plan_thr[i]));
      end
      return f;
   endfunction

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      script_row_type script [19];
      frame_type      f;
      logic [4:0]     pat;
      int             pos;
      int             pick;
      bit             no_clear;

      // samples listed from sensor 4 down to sensor 0; reset thresholds, zero gains
      script = '{
         {LT, LT, LT, LT, LT, 1'b1, 8'd50,  8'd50,  4'(0),  1'b0},
         {LT, LT, LT, LT, DK, 1'b1, 8'd100, 8'd100, 4'(-4), 1'b0},
         {LT, LT, LT, DK, DK, 1'b1, 8'd100, 8'd100, 4'(-3), 1'b0},
         {LT, LT, LT, DK, LT, 1'b1, 8'd100, 8'd100, 4'(-2), 1'b0},
         {LT, LT, DK, DK, LT, 1'b1, 8'd100, 8'd100, 4'(-1), 1'b0},
         {LT, LT, DK, LT, LT, 1'b1, 8'd50,  8'd50,  4'(0),  1'b0},
         {LT, DK, DK, LT, LT, 1'b1, 8'd100, 8'd100, 4'(1),  1'b0},
         {LT, DK, LT, LT, LT, 1'b1, 8'd100, 8'd100, 4'(2),  1'b0},
         {DK, DK, LT, LT, LT, 1'b1, 8'd100, 8'd100, 4'(3),  1'b0},
         {DK, LT, LT, LT, LT, 1'b1, 8'd100, 8'd100, 4'(4),  1'b0},
         // first entry into all dark, then a repeat that must not count
         {DK, DK, DK, DK, DK, 1'b1, 8'd100, 8'd100, 4'(4),  1'b0},
         {DK, DK, DK, DK, DK, 1'b1, 8'd100, 8'd100, 4'(4),  1'b0},
         // unknown pattern keeps the last error
         {LT, LT, DK, LT, DK, 1'b1, 8'd100, 8'd100, 4'(4),  1'b0},
         // second entry: motors stop
         {DK, DK, DK, DK, DK, 1'b1, 8'd0,   8'd0,   4'(4),  1'b1},
         {LT, DK, LT, DK, LT, 1'b1, 8'd0,   8'd0,   4'(4),  1'b1},
         // samples equal to the thresholds read light
         {THRESH_RST_4, THRESH_RST_3, THRESH_RST_2, THRESH_RST_1, THRESH_RST_0,
          1'b1, 8'd0, 8'd0, 4'(4), 1'b1},
         {THRESH_RST_4 - 12'd1, THRESH_RST_3 - 12'd1, THRESH_RST_2 - 12'd1,
          THRESH_RST_1 - 12'd1, THRESH_RST_0 - 12'd1,
          1'b1, 8'd100, 8'd100, 4'(4), 1'b0},
         // far right clears the stop count
         {DK, LT, LT, LT, LT, 1'b1, 8'd100, 8'd100, 4'(4),  1'b0},
         {LT, LT, LT, LT, DK, 1'b1, 8'd100, 8'd100, 4'(-4), 1'b0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         maybe_idle();
         send_frame(script[k].smp, script[k].typed, script[k].want);
      end

      for (int p = 1; p <= PHASES; p++) begin
         drain();
         for (int i = 0; i < NUM_SENSORS; i++) begin
            case (p)
               3: plan_thr[i] = i[0] ? LT : DK;
               6: plan_thr[i] = 12'd1;
               default: plan_thr[i] = SAMPLE_W'($urandom_range(4000, 100));
            endcase
         end
         case (p)
            1: begin
               plan_kp = GAIN_W'(511);
               plan_kd = GAIN_W'(511);
            end
            2: begin
               plan_kp = GAIN_W'(-512);
               plan_kd = GAIN_W'(-512);
            end
            4: begin
               plan_kp = GAIN_W'(511);
               plan_kd = GAIN_W'(-512);
            end
            default: if ($urandom_range(1)) begin
               plan_kp = GAIN_W'($urandom_range(60) - 30);
               plan_kd = GAIN_W'($urandom_range(60) - 30);
            end else begin
               plan_kp = GAIN_W'($urandom);
               plan_kd = GAIN_W'($urandom);
            end
         endcase
         calm = p == PHASES;
         // no far-right frames here, so the stop count climbs to saturation
         no_clear = p == 2 || p == 5 || p == 7;
         idle_pct = calm ? 0 : (p < 3 ? 25 : 15 * $urandom_range(2));
         stall_pct = calm ? 0 : (p < 3 ? 25 : 15 * $urandom_range(2));
         load_plan();

         pos = 4;
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            if (p == 4 && n == FRAMES_PER_PHASE / 2)
               drain();
            pick = $urandom_range(no_clear ? 84 : 99);
            if (pick < 55) begin
               // line drifts one position at a time, with an occasional jump
               if ($urandom_range(19) == 0)
                  pos = $urandom_range(8);
               else
                  pos = pos + $urandom_range(2) - 1;
               if (pos < 0)
                  pos = 0;
               if (pos > 8)
                  pos = 8;
               if (no_clear && pos == 8)
                  pos = 7;
               case (pos)
                  0: pat = PAT_ERR_NEG4;
                  1: pat = PAT_ERR_NEG3;
                  2: pat = PAT_ERR_NEG2;
                  3: pat = PAT_ERR_NEG1;
                  4: pat = PAT_CENTER;
                  5: pat = PAT_ERR_POS1;
                  6: pat = PAT_ERR_POS2;
                  7: pat = PAT_ERR_POS3;
                  default: pat = PAT_ERR_POS4;
               endcase
               f = frame_for(pat);
            end else if (pick < 75) begin
               f = frame_for(PAT_ALL);
            end else if (pick < 85) begin
               pat = 5'($urandom);
               if (no_clear && pat == PAT_ERR_POS4)
                  pat = PAT_ALL;
               f = frame_for(pat);
            end else begin
               for (int i = 0; i < NUM_SENSORS; i++)
                  f[i] = SAMPLE_W'($urandom);
            end
            maybe_idle();
            send_frame(f, 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lfpd_pkg.sv
rtl/lfpd_lane.sv
rtl/lfpd_merge.sv
rtl/line_follow_pd_steering.sv
rtl/lfpd_checker.sv
bench/tb_line_follow_pd_steering.sv
